FILE: src/lfowt_pkg.sv
`default_nettype none

package lfowt_pkg;

  // Wavetable geometry
  localparam int TableSize = 256;
  localparam int IdxW      = $clog2(TableSize);
  localparam int LevelW    = 16;

  // Counter and divider widths
  localparam int ElapsedW  = 25;
  localparam int CycleW    = 24;
  localparam int PosW      = 48;
  localparam int IncW      = ElapsedW + 1;
  localparam int DivSteps  = PosW + IdxW;
  localparam int CntW      = $clog2(DivSteps + 1);

  // Register reset values
  localparam logic [CycleW-1:0] CycleReset    = CycleW'(96000);
  localparam logic [15:0]       ToneStepReset = 16'd273;

  // Sine polynomial coefficients, Q15
  localparam logic [15:0] HalfQ15 = 16'd32768;
  localparam logic [15:0] SineA   = 16'd25395;
  localparam logic [12:0] SineB   = 13'd7373;
  localparam logic [14:0] SineMax = 15'd32767;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_SYNC    = 2'd1,
    MODE_ONESHOT = 2'd2,
    MODE_LATCH   = 2'd3
  } lfo_mode_e;

  // Mode in which the last note came; a code above the modes means no note yet
  localparam logic [2:0] NoteNone = 3'd4;

  typedef enum logic [1:0] {
    CFG_LFO_MODE      = 2'd0,
    CFG_CYCLE_SAMPLES = 2'd1,
    CFG_TONE_STEP     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                    command;
    logic                    note_on;
    logic                    note_off;
    logic                    block_start;
    logic signed [PosW-1:0]  host_position;
    logic [7:0]              entry_index;
    logic [LevelW-1:0]       entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        lfo_index;
    logic [LevelW-1:0] lfo_level;
    logic signed [15:0] audio_out;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: src/lfowt_div.sv
`default_nettype none

// Restoring long division, one bit per cycle. The dividend is left-aligned;
// once its bits are used up zeros shift in, so the last IdxW steps yield the
// quotient of remainder * TableSize / divisor.
module lfowt_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire lfowt_pkg::div_ctl_t     ctl_i,
  input  wire [lfowt_pkg::PosW-1:0]    dividend_i,
  input  wire [lfowt_pkg::CycleW-1:0]  cyc_i,
  output lfowt_pkg::div_sts_t          sts_o,
  output logic [lfowt_pkg::CycleW-1:0] rem_o,
  output logic [lfowt_pkg::IdxW-1:0]   quo_o
);
  import lfowt_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PosW-1:0]   dvd_q;
  logic [CycleW-1:0] rem_q;
  logic [CycleW-1:0] mod_q;
  logic [IdxW-1:0]   quo_q;

  logic [CycleW:0]   trial;
  logic [CycleW:0]   diff;
  logic              ge;
  logic [CycleW-1:0] rem_nx;

  always_comb begin
    trial  = {rem_q, dvd_q[PosW-1]};
    diff   = trial - {1'b0, cyc_i};
    ge     = (trial >= {1'b0, cyc_i});
    rem_nx = ge ? diff[CycleW-1:0] : trial[CycleW-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ctl_i.steps;
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PosW-2:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[IdxW-2:0], ge};
      // last dividend bit: keep the true remainder
      if (cnt_q == CntW'(IdxW + 1)) begin
        mod_q <= rem_nx;
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = mod_q;
  assign quo_o      = quo_q;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(ctl_i.start) |-> rem_q < cyc_i)
    else $error("partial remainder reached divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a finished division");
  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("division started while busy");
`endif

endmodule

`default_nettype wire

FILE: src/lfo_wavetable_tremolo.sv
`default_nettype none

// Wavetable LFO tremolo on a sine tone. Each input transfer is either a
// wavetable write (no result) or a sample tick that yields one result: the
// LFO table index, the table level there, and the sine tone scaled by that
// level. A tick runs through the shared bit-serial divider, which reduces the
// counter (26 bits, or the 48-bit host position in sync mode) modulo the
// cycle length and then divides for the 8-bit table index, one bit per
// cycle, followed by the wavetable memory read and the level multiply. The
// result sits in an output register, so the next tick is taken while it
// waits. Table entries read before being written are undefined.
module lfo_wavetable_tremolo (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire lfowt_pkg::in_item_t     in_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output lfowt_pkg::out_item_t         out_item_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [1:0]                    cfg_addr_i,
  input  wire [lfowt_pkg::CycleW-1:0]  cfg_data_i
);
  import lfowt_pkg::*;

  state_e state_q, state_d;

  // Configuration
  lfo_mode_e         lfo_mode_q;
  logic [CycleW-1:0] cycle_q;
  logic [15:0]       step_q;
  logic [CycleW-1:0] cyc;

  // LFO and tone state
  logic [ElapsedW-1:0] elapsed_q;
  logic                held_q;
  logic [2:0]          nmode_q;
  logic [15:0]         phase_q;
  logic                keep_q;
  logic [ElapsedW-1:0] hold_e_q;

  // Accept-time decode
  logic                in_acc;
  logic                tick_acc;
  logic                wr_acc;
  logic [ElapsedW-1:0] e_pre;
  logic                held_d;
  logic [2:0]          nmode_d;
  logic [IncW-1:0]     inc;
  logic [ElapsedW-1:0] y_os;
  logic [IncW-1:0]     short_dvd;
  logic [PosW-1:0]     dividend;
  logic                sync_mode;
  logic                keep_d;
  logic [15:0]         phase_base;

  // Divider
  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [CycleW-1:0] div_rem;
  logic [IdxW-1:0]   div_quo;

  // Wavetable memory
  logic [LevelW-1:0] wave_mem [TableSize];
  logic [LevelW-1:0] rd_q;

  // Sine pipeline
  logic [30:0]       p1;
  logic [15:0]       y1_q, y2_q;
  logic              sg1_q, sg2_q, sg3_q;
  logic [28:0]       p2;
  logic [15:0]       c2_q;
  logic [31:0]       p3;
  logic [14:0]       s3_q;

  // Result
  logic [IdxW-1:0]   idx_q;
  logic [LevelW-1:0] level_q;
  logic [30:0]       p4;
  logic [14:0]       mag_q;
  logic              neg_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              out_load;

  assign cyc         = (cycle_q == '0) ? CycleW'(1) : cycle_q;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_mode_q <= MODE_FREE;
      cycle_q    <= CycleReset;
      step_q     <= ToneStepReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_LFO_MODE:      lfo_mode_q <= lfo_mode_e'(cfg_data_i[1:0]);
        CFG_CYCLE_SAMPLES: cycle_q    <= cfg_data_i;
        CFG_TONE_STEP:     step_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Note flags, then the counter dividend by mode
  always_comb begin
    e_pre   = in_item_i.note_on ? '0 : elapsed_q;
    held_d  = held_q;
    nmode_d = nmode_q;
    if (in_item_i.note_on) begin
      held_d  = 1'b1;
      nmode_d = {1'b0, lfo_mode_q};
    end
    if (in_item_i.note_off) begin
      held_d  = 1'b0;
      nmode_d = {1'b0, lfo_mode_q};
    end
    inc  = {1'b0, e_pre} + IncW'(1);
    y_os = (({1'b0, e_pre} < {2'b0, cyc}) && (nmode_d == {1'b0, MODE_ONESHOT}))
           ? inc[ElapsedW-1:0] : e_pre;

    sync_mode = 1'b0;
    keep_d    = 1'b0;
    case (lfo_mode_q)
      MODE_FREE:    short_dvd = inc;
      MODE_ONESHOT: begin
        short_dvd = {1'b0, y_os};
        keep_d    = 1'b1;
      end
      MODE_LATCH:   short_dvd = held_d ? inc : '0;
      default: begin
        short_dvd = '0;
        sync_mode = 1'b1;
      end
    endcase

    if (sync_mode) begin
      dividend = in_item_i.host_position[PosW-1] ? '0 : PosW'(in_item_i.host_position);
    end else begin
      dividend = {short_dvd, {(PosW - IncW){1'b0}}};
    end

    phase_base = in_item_i.block_start ? '0 : phase_q;
  end

  // Control
  always_comb begin
    state_d       = state_q;
    in_stall_o    = (state_q != ST_IDLE);
    div_ctl.start = 1'b0;
    div_ctl.steps = sync_mode ? CntW'(PosW + IdxW) : CntW'(IncW + IdxW);
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_item_i.command == CMD_TICK) begin
          div_ctl.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign tick_acc = in_acc && (in_item_i.command == CMD_TICK);
  assign wr_acc   = in_acc && (in_item_i.command == CMD_WRITE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      held_q      <= 1'b0;
      nmode_q     <= NoteNone;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tick_acc) begin
        held_q  <= held_d;
        nmode_q <= nmode_d;
        phase_q <= phase_base + step_q;
      end
      if (state_q == ST_DIV && div_sts.done) begin
        elapsed_q <= keep_q ? hold_e_q : ElapsedW'(div_rem);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      keep_q   <= keep_d;
      hold_e_q <= y_os;
    end
    if (state_q == ST_DIV && div_sts.done) begin
      idx_q <= div_quo;
    end
    if (state_q == ST_READ) begin
      level_q <= rd_q;
      mag_q   <= p4[30:16];
      neg_q   <= sg3_q;
    end
    if (out_load) begin
      out_q.lfo_index <= 8'(idx_q);
      out_q.lfo_level <= level_q;
      out_q.audio_out <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    end
  end

  // Wavetable: write on a write transfer, read at the index from the divider
  always_ff @(posedge clk_i) begin
    if (wr_acc && (32'(in_item_i.entry_index) < TableSize)) begin
      wave_mem[in_item_i.entry_index[IdxW-1:0]] <= in_item_i.entry_value;
    end
    if (state_q == ST_DIV && div_sts.done) begin
      rd_q <= wave_mem[div_quo];
    end
  end

  // Sine of the tone phase; settles long before the division ends
  always_comb begin
    p1 = 31'(phase_q[14:0]) * 31'(HalfQ15 - {1'b0, phase_q[14:0]});
    p2 = 29'(SineB) * 29'(y1_q);
    p3 = 32'(y2_q) * 32'(c2_q);
    p4 = 31'(s3_q) * 31'(rd_q);
  end

  always_ff @(posedge clk_i) begin
    y1_q  <= p1[28:13];
    sg1_q <= phase_q[15];
    y2_q  <= y1_q;
    c2_q  <= SineA + 16'(p2[28:15]);
    sg2_q <= sg1_q;
    s3_q  <= (p3[31:15] > 17'(SineMax)) ? SineMax : p3[29:15];
    sg3_q <= sg2_q;
  end

  lfowt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (dividend),
    .cyc_i      (cyc),
    .sts_o      (div_sts),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");
  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_sts.busy || div_sts.done)
    else $error("waiting on an idle divider");
  a_phase_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE && $past(state_q) != ST_IDLE |-> $stable(phase_q))
    else $error("tone phase moved during a tick");
  a_wrapped_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ && lfo_mode_q != MODE_ONESHOT |-> elapsed_q < {1'b0, cyc})
    else $error("wrapped counter not below cycle length");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("result overwrote a waiting result");
`endif

endmodule

`default_nettype wire
